// File: hdl/b64d_pkg.sv
// shared types, constants and the character decode function of the base64 stream decoder
package b64d_pkg;

    // width of the per-message byte counter
    localparam int CNT_W = 16;
    // width of the output limit register and of the reported byte count
    localparam int LIM_W = 16;
    localparam logic [LIM_W-1:0] LIMIT_RESET = '1;

    // queue depths, powers of two so the pointers wrap on their own
    localparam int CMD_Q_DEPTH = 4;
    localparam int CMD_Q_AW    = $clog2(CMD_Q_DEPTH);
    localparam int RES_Q_DEPTH = 4;
    localparam int RES_Q_AW    = $clog2(RES_Q_DEPTH);

    localparam logic [5:0] SYM_PLUS  = 6'd62;
    localparam logic [5:0] SYM_SLASH = 6'd63;
    localparam logic [5:0] SYM_LOWER = 6'd26;
    localparam logic [5:0] SYM_DIGIT = 6'd52;

    typedef enum logic [1:0] {
        SYM_DATA,
        SYM_PAD,
        SYM_BAD
    } t_sym_kind;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_BAD_CHAR = 2'd1,
        STAT_OVERFLOW = 2'd2
    } t_status;

    typedef struct packed {
        t_sym_kind  kind;
        logic [5:0] value;
    } t_sym;

    // one classified request between front and back
    typedef struct packed {
        t_sym sym;
        logic eom;
    } t_cmd;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic             byte_valid;
        t_status          status;
        logic             message_end;
        logic [LIM_W-1:0] byte_count;
    } t_result;

    // queue handshake between two parts
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

    function automatic t_sym sym_decode(input logic [7:0] c);
        t_sym s;
        s.kind  = SYM_DATA;
        s.value = '0;
        if (c >= 8'h41 && c <= 8'h5a) begin
            s.value = 6'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7a) begin
            s.value = 6'(c - 8'h61) + SYM_LOWER;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            s.value = 6'(c - 8'h30) + SYM_DIGIT;
        end else if (c == 8'h2b) begin
            s.value = SYM_PLUS;
        end else if (c == 8'h2f) begin
            s.value = SYM_SLASH;
        end else if (c == 8'h3d) begin
            s.kind = SYM_PAD;
        end else begin
            s.kind = SYM_BAD;
        end
        return s;
    endfunction

endpackage

// File: hdl/base64_stream_decoder.sv
// top level: a push is written into the four-entry command queue, and the combinational
// back stage writes its result into the four-entry result queue; one character accepted
// per cycle while the command queue is not full; the back stage stalls on a full result queue.
// synchronous active-low reset empties both queues, clears message state and
// sets the output limit to 65535; no clearing pass.
module base64_stream_decoder import b64d_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    output logic             full,
    input  logic [7:0]       i_in_char,
    input  logic             i_end_of_message,
    output logic             empty,
    input  logic             pop,
    output logic [7:0]       o_out_byte,
    output logic             o_byte_valid,
    output logic [1:0]       o_status,
    output logic             o_message_end,
    output logic [LIM_W-1:0] o_byte_count,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [LIM_W-1:0] i_cfg_data
);

    t_q_stat cmd_stat;
    t_q_stat res_stat;
    t_cmd    front_cmd;
    t_cmd    q_cmd;
    logic    front_wr;
    logic    cmd_rd;
    logic    res_wr;
    t_result back_res;
    t_result q_res;

    assign o_cfg_ready = 1'b1;

    b64d_front u_front (
        .i_push           (push),
        .i_in_char        (i_in_char),
        .i_end_of_message (i_end_of_message),
        .i_q_full         (cmd_stat.full),
        .o_wr_en          (front_wr),
        .o_cmd            (front_cmd),
        .o_full           (full)
    );

    b64d_cmd_q u_cmd_q (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (front_wr),
        .i_wr_data (front_cmd),
        .i_rd_en   (cmd_rd),
        .o_rd_data (q_cmd),
        .o_stat    (cmd_stat)
    );

    b64d_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_stat  (cmd_stat),
        .i_cmd       (q_cmd),
        .o_cmd_rd    (cmd_rd),
        .i_res_stat  (res_stat),
        .o_res_wr    (res_wr),
        .o_res       (back_res)
    );

    b64d_res_q u_res_q (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (res_wr),
        .i_wr_data (back_res),
        .i_rd_en   (pop),
        .o_rd_data (q_res),
        .o_stat    (res_stat)
    );

    assign empty         = res_stat.empty;
    assign o_out_byte    = q_res.out_byte;
    assign o_byte_valid  = q_res.byte_valid;
    assign o_status      = q_res.status;
    assign o_message_end = q_res.message_end;
    assign o_byte_count  = q_res.byte_count;

endmodule

// File: hdl/b64d_front.sv
// front end: takes characters and classifies them into symbol requests
module b64d_front import b64d_pkg::*; (
    input  logic       i_push,
    input  logic [7:0] i_in_char,
    input  logic       i_end_of_message,
    input  logic       i_q_full,
    output logic       o_wr_en,
    output t_cmd       o_cmd,
    output logic       o_full
);

    assign o_full  = i_q_full;
    assign o_wr_en = i_push && !i_q_full;

    always_comb begin
        o_cmd.sym = sym_decode(i_in_char);
        o_cmd.eom = i_end_of_message;
    end

endmodule

// File: hdl/b64d_cmd_q.sv
// small queue of classified requests between front and back
module b64d_cmd_q import b64d_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_wr_en,
    input  t_cmd    i_wr_data,
    input  logic    i_rd_en,
    output t_cmd    o_rd_data,
    output t_q_stat o_stat
);

    t_cmd                r_mem [CMD_Q_DEPTH];
    logic [CMD_Q_AW-1:0] r_wr_ptr;
    logic [CMD_Q_AW-1:0] r_rd_ptr;
    logic [CMD_Q_AW:0]   r_count;
    logic                wr_go;
    logic                rd_go;

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == (CMD_Q_AW+1)'(CMD_Q_DEPTH));
    assign wr_go        = i_wr_en && !o_stat.full;
    assign rd_go        = i_rd_en && !o_stat.empty;
    assign o_rd_data    = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_go) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (rd_go) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (wr_go && !rd_go) begin
                r_count <= r_count + 1'b1;
            end else if (rd_go && !wr_go) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_go) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

// File: hdl/b64d_back.sv
// back end: bit accumulator, byte counter, error tracking and the limit register
module b64d_back import b64d_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    input  logic [LIM_W-1:0] i_cfg_data,
    input  t_q_stat          i_cmd_stat,
    input  t_cmd             i_cmd,
    output logic             o_cmd_rd,
    input  t_q_stat          i_res_stat,
    output logic             o_res_wr,
    output t_result          o_res
);

    localparam int CMP_W = (CNT_W > LIM_W) ? CNT_W : LIM_W;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    logic [5:0]       r_held_bits;
    logic [2:0]       r_held_cnt;
    logic [CNT_W-1:0] r_bytes;
    logic             r_failed;
    logic             r_fail_ovf;
    logic [LIM_W-1:0] r_limit;

    logic [5:0]       n_held_bits;
    logic [2:0]       n_held_cnt;
    logic [CNT_W-1:0] n_bytes;
    logic             n_failed;
    logic             n_fail_ovf;

    logic             go;
    logic             at_limit;
    logic [11:0]      acc;
    logic             have_byte;
    logic [7:0]       byte_val;

    assign go       = !i_cmd_stat.empty && !i_res_stat.full;
    assign o_cmd_rd = go;
    assign acc      = {r_held_bits, i_cmd.sym.value};
    // saturating the limit to the counter range is the same as also stopping at the max
    assign at_limit = (CMP_W'(r_bytes) >= CMP_W'(r_limit)) || (r_bytes == CNT_MAX);

    always_comb begin
        n_held_bits = r_held_bits;
        n_held_cnt  = r_held_cnt;
        n_bytes     = r_bytes;
        n_failed    = r_failed;
        n_fail_ovf  = r_fail_ovf;
        have_byte   = 1'b0;
        byte_val    = '0;
        if (!r_failed) begin
            case (i_cmd.sym.kind)
                SYM_PAD: begin
                    n_held_bits = '0;
                    n_held_cnt  = '0;
                end
                SYM_DATA: begin
                    if (r_held_cnt == 3'd0) begin
                        n_held_bits = i_cmd.sym.value;
                        n_held_cnt  = 3'd6;
                    end else if (at_limit) begin
                        n_failed   = 1'b1;
                        n_fail_ovf = 1'b1;
                    end else begin
                        have_byte = 1'b1;
                        n_bytes   = r_bytes + 1'b1;
                        case (r_held_cnt)
                            3'd2: begin
                                byte_val    = acc[7:0];
                                n_held_bits = '0;
                                n_held_cnt  = 3'd0;
                            end
                            3'd4: begin
                                byte_val    = acc[9:2];
                                n_held_bits = {4'd0, acc[1:0]};
                                n_held_cnt  = 3'd2;
                            end
                            default: begin
                                byte_val    = acc[11:4];
                                n_held_bits = {2'd0, acc[3:0]};
                                n_held_cnt  = 3'd4;
                            end
                        endcase
                    end
                end
                default: begin
                    n_failed   = 1'b1;
                    n_fail_ovf = 1'b0;
                end
            endcase
        end

        o_res.out_byte    = byte_val;
        o_res.byte_valid  = have_byte;
        o_res.message_end = i_cmd.eom;
        o_res.byte_count  = LIM_W'(n_bytes);
        if (!n_failed) begin
            o_res.status = STAT_OK;
        end else if (n_fail_ovf) begin
            o_res.status = STAT_OVERFLOW;
        end else begin
            o_res.status = STAT_BAD_CHAR;
        end
        o_res_wr = go && (have_byte || i_cmd.eom);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_bits <= '0;
            r_held_cnt  <= '0;
            r_bytes     <= '0;
            r_failed    <= 1'b0;
            r_fail_ovf  <= 1'b0;
            r_limit     <= LIMIT_RESET;
        end else begin
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
            if (go) begin
                if (i_cmd.eom) begin
                    r_held_bits <= '0;
                    r_held_cnt  <= '0;
                    r_bytes     <= '0;
                    r_failed    <= 1'b0;
                    r_fail_ovf  <= 1'b0;
                end else begin
                    r_held_bits <= n_held_bits;
                    r_held_cnt  <= n_held_cnt;
                    r_bytes     <= n_bytes;
                    r_failed    <= n_failed;
                    r_fail_ovf  <= n_fail_ovf;
                end
            end
        end
    end

endmodule

// File: hdl/b64d_res_q.sv
// result queue that feeds the output ports
module b64d_res_q import b64d_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_wr_en,
    input  t_result i_wr_data,
    input  logic    i_rd_en,
    output t_result o_rd_data,
    output t_q_stat o_stat
);

    t_result             r_mem [RES_Q_DEPTH];
    logic [RES_Q_AW-1:0] r_wr_ptr;
    logic [RES_Q_AW-1:0] r_rd_ptr;
    logic [RES_Q_AW:0]   r_count;
    logic                wr_go;
    logic                rd_go;

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == (RES_Q_AW+1)'(RES_Q_DEPTH));
    assign wr_go        = i_wr_en && !o_stat.full;
    assign rd_go        = i_rd_en && !o_stat.empty;
    assign o_rd_data    = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_go) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (rd_go) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (wr_go && !rd_go) begin
                r_count <= r_count + 1'b1;
            end else if (rd_go && !wr_go) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_go) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

// File: tb/sv/tb.sv
// self-checking testbench for the base64 stream decoder, with a built-in bit-level predictor
module tb;
    import b64d_pkg::*;

    localparam int RANDOM_ITEMS  = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 200;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             push;
    logic             full;
    logic [7:0]       i_in_char;
    logic             i_end_of_message;
    logic             empty;
    logic             pop;
    logic [7:0]       o_out_byte;
    logic             o_byte_valid;
    logic [1:0]       o_status;
    logic             o_message_end;
    logic [LIM_W-1:0] o_byte_count;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [LIM_W-1:0] i_cfg_data;

    base64_stream_decoder i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_in_char        (i_in_char),
        .i_end_of_message (i_end_of_message),
        .empty            (empty),
        .pop              (pop),
        .o_out_byte       (o_out_byte),
        .o_byte_valid     (o_byte_valid),
        .o_status         (o_status),
        .o_message_end    (o_message_end),
        .o_byte_count     (o_byte_count),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // decoder shadow state
    logic [LIM_W-1:0] byte_limit;
    logic [5:0]       acc_bits;
    int unsigned      acc_count;
    logic [CNT_W-1:0] msg_bytes;
    logic             msg_failed;
    logic             fail_overflow;

    t_result     decoded_q[$];
    int          err_count;
    int          live_chars;
    bit          tx_idle;
    bit          rx_idle;
    bit          rx_on;
    int          pop_wait;
    int          quiet_cycles;

    task automatic report(input string what, input int got, input int want);
        $display("mismatch: %s got %0d expected %0d (t=%0t)", what, got, want, $time);
        err_count++;
    endtask

    function automatic t_sym_kind classify(input logic [7:0] c, output logic [5:0] v);
        v = '0;
        if (c >= "A" && c <= "Z") begin
            v = 6'(c - "A");
        end else if (c >= "a" && c <= "z") begin
            v = 6'(c - "a" + 8'd26);
        end else if (c >= "0" && c <= "9") begin
            v = 6'(c - "0" + 8'd52);
        end else if (c == "+") begin
            v = 6'd62;
        end else if (c == "/") begin
            v = 6'd63;
        end else if (c == "=") begin
            return SYM_PAD;
        end else begin
            return SYM_BAD;
        end
        return SYM_DATA;
    endfunction

    function automatic logic [7:0] alphabet_char(input int unsigned v);
        if (v < 26) return 8'("A" + v);
        if (v < 52) return 8'("a" + v - 26);
        if (v < 62) return 8'("0" + v - 52);
        if (v == 62) return "+";
        return "/";
    endfunction

    function automatic void clear_message();
        acc_bits      = '0;
        acc_count     = 0;
        msg_bytes     = '0;
        msg_failed    = 1'b0;
        fail_overflow = 1'b0;
    endfunction

    // advance the shadow decoder by one character, queue the result it causes
    function automatic void decode_step(input logic [7:0] c, input logic eom);
        t_sym_kind   kind;
        logic [5:0]  v;
        logic [11:0] acc;
        int unsigned n;
        logic        have_byte = 1'b0;
        logic [7:0]  dbyte = '0;
        t_result     r;
        live_chars++;
        if (!msg_failed) begin
            kind = classify(c, v);
            if (kind == SYM_PAD) begin
                acc_bits  = '0;
                acc_count = 0;
            end else if (kind == SYM_BAD) begin
                msg_failed    = 1'b1;
                fail_overflow = 1'b0;
            end else begin
                acc = {acc_bits, v};
                n   = acc_count + 6;
                if (n >= 8) begin
                    if (msg_bytes >= byte_limit) begin
                        msg_failed    = 1'b1;
                        fail_overflow = 1'b1;
                    end else begin
                        n         = n - 8;
                        dbyte     = 8'(acc >> n);
                        acc_bits  = 6'(acc & ((12'd1 << n) - 12'd1));
                        acc_count = n;
                        msg_bytes = msg_bytes + 1'b1;
                        have_byte = 1'b1;
                    end
                end else begin
                    acc_bits  = acc[5:0];
                    acc_count = n;
                end
            end
        end
        if (have_byte || eom) begin
            r.out_byte    = dbyte;
            r.byte_valid  = have_byte;
            r.status      = !msg_failed ? STAT_OK
                          : (fail_overflow ? STAT_OVERFLOW : STAT_BAD_CHAR);
            r.message_end = eom;
            r.byte_count  = LIM_W'(msg_bytes);
            decoded_q.push_back(r);
        end
        if (eom) clear_message();
    endfunction

    // called just after a falling edge, returns just after a falling edge
    task automatic send_char(input logic [7:0] c, input logic eom);
        int gap;
        gap = tx_idle ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push             <= 1'b1;
        i_in_char        <= c;
        i_end_of_message <= eom;
        do @(posedge i_clk); while (full);
        decode_step(c, eom);
        @(negedge i_clk);
    endtask

    task automatic send_string(input string s, input bit eom_last);
        for (int i = 0; i < s.len(); i++) begin
            send_char(s[i], eom_last && (i == s.len() - 1));
        end
    endtask

    // hold off until every queued result is out and the pipe is empty
    task automatic drain_results();
        push <= 1'b0;
        while (decoded_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_limit(input logic [LIM_W-1:0] v);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        byte_limit = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_random_message();
        int          len;
        int          kind;
        int          pads;
        logic [7:0]  c;
        len  = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 96) : $urandom_range(1, 16);
        kind = $urandom_range(0, 9);
        pads = (kind < 7 && $urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0;
        for (int i = 0; i < len; i++) begin
            c = alphabet_char($urandom_range(0, 63));
            if (kind == 9 || (kind >= 7 && $urandom_range(0, 99) < 3)) begin
                c = 8'($urandom_range(0, 255));
            end
            if (i >= len - pads) c = "=";
            send_char(c, i == len - 1);
        end
    endtask

    // every alphabet edge, last byte completed on the end request
    task automatic test_alphabet();
        send_string("AZaz09+/", 1'b1);
    endtask

    // pad drops held bits mid-message
    task automatic test_pad();
        send_string("QQ=Q", 1'b1);
    endtask

    // invalid char, then the rest of the message is dropped
    task automatic test_bad_char();
        send_char("A", 1'b0);
        send_char(8'h00, 1'b0);
        send_char(8'hff, 1'b0);
        send_char("B", 1'b1);
    endtask

    task automatic test_overflow();
        write_limit('0);
        send_string("AA", 1'b1);
        write_limit(16'd1);
        send_string("ABCD", 1'b1);
        write_limit('1);
        // end request carrying a pad
        send_string("TQ==", 1'b1);
    endtask

    task automatic test_random();
        while (live_chars < RANDOM_ITEMS) begin
            case ($urandom_range(0, 3))
                0: write_limit(LIM_W'($urandom_range(0, 24)));
                1: write_limit('1);
                2: write_limit(LIM_W'($urandom_range(0, 65535)));
                default: drain_results();
            endcase
            tx_idle = $urandom_range(0, 3) != 0;
            rx_idle = $urandom_range(0, 3) != 0;
            repeat (8) send_random_message();
        end
    endtask

    // result checker
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (rx_on && pop && !empty) begin
            if (decoded_q.size() == 0) begin
                report("result with no request pending, byte", o_out_byte, 0);
            end else begin
                want = decoded_q.pop_front();
                if (o_out_byte !== want.out_byte) report("out_byte", o_out_byte, want.out_byte);
                if (o_byte_valid !== want.byte_valid) begin
                    report("byte_valid", o_byte_valid, want.byte_valid);
                end
                if (o_status !== want.status) report("status", o_status, want.status);
                if (o_message_end !== want.message_end) begin
                    report("message_end", o_message_end, want.message_end);
                end
                if (o_byte_count !== want.byte_count) begin
                    report("byte_count", o_byte_count, want.byte_count);
                end
            end
            pop_wait = rx_idle ? $urandom_range(0, 7) : 0;
        end
    end

    always @(negedge i_clk) begin
        if (!rx_on) begin
            pop <= 1'b0;
        end else if (pop_wait > 0) begin
            pop <= 1'b0;
            pop_wait--;
        end else begin
            pop <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (rx_on) begin
            if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("FAIL base64_stream_decoder");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n          = 1'b0;
        push             = 1'b0;
        pop              = 1'b0;
        i_in_char        = '0;
        i_end_of_message = 1'b0;
        i_cfg_valid      = 1'b0;
        i_cfg_data       = '0;
        err_count        = 0;
        live_chars       = 0;
        tx_idle          = 1'b1;
        rx_idle          = 1'b1;
        rx_on            = 1'b0;
        pop_wait         = 0;
        quiet_cycles     = 0;
        byte_limit       = LIMIT_RESET;
        clear_message();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        rx_on = 1'b1;
        @(negedge i_clk);

        test_alphabet();
        test_pad();
        test_bad_char();
        test_overflow();
        test_random();

        drain_results();
        if (err_count == 0) begin
            $display("PASS base64_stream_decoder");
        end else begin
            $display("FAIL base64_stream_decoder");
        end
        $finish;
    end

endmodule
